>>> hw/rtl/mlp_two_layer_sigmoid_classifier_macros.svh
// ---------------------------------------------------------------------------
// mlp_two_layer_sigmoid_classifier_macros
// assertion helper macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef MLP_TWO_LAYER_SIGMOID_CLASSIFIER_MACROS_SVH
`define MLP_TWO_LAYER_SIGMOID_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MLPSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MLPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mlpsc_pkg.sv
// ---------------------------------------------------------------------------
// mlpsc_pkg
// types, request codes and sigmoid table builder of the classifier
// ---------------------------------------------------------------------------
package mlpsc_pkg;

   // request codes
   localparam logic [1:0] REQ_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_BIAS   = 2'd1;
   localparam logic [1:0] REQ_PIXEL  = 2'd2;

   localparam int PIXEL_MAX = 4096;

   typedef struct packed {
      logic [1:0]         req_type;
      logic               layer_select;
      logic [4:0]         row_index;
      logic [9:0]         column_index;
      logic signed [15:0] value;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  predicted_class;
      logic [12:0] top_activation;
   } rsp_item_type;

   // (a * b) >> 60 in Q60
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // restoring shift-subtract quotient, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid table entry k for a table step of step (Q4.12 units)
   function automatic logic [12:0] sig_entry(input int k, input int step);
      logic [63:0] pw [16];
      logic [63:0] e;
      logic [63:0] term;
      logic [63:0] ex;
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] v;
      logic [31:0] a;
      int          q;
      e    = 64'd1 << 60;
      term = 64'd1 << 60;
      // exp(-1/4096) by a short series
      for (int n = 1; n <= 6; n++) begin
         term = udiv64(term >> 12, 64'(n));
         if (n % 2 == 1) e = e - term;
         else            e = e + term;
      end
      pw[0] = e;
      for (int j = 1; j < 16; j++) pw[j] = fx_mul(pw[j-1], pw[j-1]);
      q  = k * step - 32768;
      a  = 32'(q < 0 ? -q : q) & 32'h0000_ffff;
      ex = 64'd1 << 60;
      for (int j = 0; j < 16; j++) begin
         if (a[j]) ex = fx_mul(ex, pw[j]);
      end
      d = ((64'd1 << 60) + ex) >> 20;
      if (q >= 0) begin
         v = (udiv64(64'd1 << 53, d) + 64'd1) >> 1;
      end else begin
         num = ex >> 20;
         v   = (udiv64(num << 13, d) + 64'd1) >> 1;
      end
      return v[12:0];
   endfunction

endpackage

>>> hw/rtl/mlpsc_sigmoid_rom.sv
// ---------------------------------------------------------------------------
// mlpsc_sigmoid_rom
// constant sigmoid table with a registered read port
// ---------------------------------------------------------------------------
module mlpsc_sigmoid_rom #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_index,
   output logic [12:0]              rd_data
);
   import mlpsc_pkg::*;

   localparam int STEP = 65536 / DEPTH;

   logic [12:0] rom_tbl [DEPTH];
   logic [12:0] rd_data_ff;

   // table contents fixed at elaboration
   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [12:0] ENTRY = sig_entry(k, STEP);
      assign rom_tbl[k] = ENTRY;
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= rom_tbl[rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mlp_two_layer_sigmoid_classifier.sv
// ---------------------------------------------------------------------------
// mlp_two_layer_sigmoid_classifier
// two-layer fully connected sigmoid network with argmax on the output layer
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_stall   req_item_type (weight, bias, pixel)
//  rsp_     out        rsp_valid/rsp_stall   rsp_item_type (class, activation)
//
//  weight, bias and plain pixel requests are written to their stores when taken.
//  a last pixel runs inference on one shared multiply-accumulate fed by a
//  one-read-per-cycle weight memory; req_stall stays high throughout.
//  the result sits in an output register; later requests are taken while it waits.
//  reset clears control state only; stores are undefined until written.
// ---------------------------------------------------------------------------
module mlp_two_layer_sigmoid_classifier #(
   parameter int INPUT_COUNT         = 784,
   parameter int HIDDEN_COUNT        = 30,
   parameter int OUTPUT_COUNT        = 10,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mlpsc_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mlpsc_pkg::rsp_item_type rsp_data
);
   import mlpsc_pkg::*;

   localparam int HW_DEPTH = HIDDEN_COUNT * INPUT_COUNT;
   localparam int OW_DEPTH = OUTPUT_COUNT * HIDDEN_COUNT;
   localparam int HW_AW    = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
   localparam int OW_AW    = (OW_DEPTH > 1) ? $clog2(OW_DEPTH) : 1;
   localparam int PX_AW    = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int HB_AW    = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
   localparam int OB_AW    = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
   localparam int MAX_IN   = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
   localparam int CNT_W    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
   localparam int MAX_N    = (HIDDEN_COUNT > OUTPUT_COUNT) ? HIDDEN_COUNT : OUTPUT_COUNT;
   localparam int N_W      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int ACC_W    = 30 + CNT_W;
   localparam int ZW       = ACC_W - 11;
   localparam int IDX_W    = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int STEP     = 65536 / SIGMOID_TABLE_DEPTH;
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / STEP);
   localparam logic signed [ZW-1:0] Z_MIN = ZW'(-32768);
   localparam logic signed [ZW-1:0] Z_MAX = ZW'(32767);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_ACT   = 3'd4;
   localparam logic [2:0] S_ROM   = 3'd5;
   localparam logic [2:0] S_STORE = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // stores
   logic signed [15:0] hw_mem [HW_DEPTH];
   logic signed [15:0] ow_mem [OW_DEPTH];
   logic signed [15:0] hb_mem [HIDDEN_COUNT];
   logic signed [15:0] ob_mem [OUTPUT_COUNT];
   logic [12:0]        px_mem [INPUT_COUNT];
   logic [12:0]        ha_mem [HIDDEN_COUNT];

   logic signed [15:0] hw_rd_ff, ow_rd_ff, hb_rd_ff, ob_rd_ff;
   logic [12:0]        px_rd_ff, ha_rd_ff;

   // control registers
   logic [2:0]       state_ff, state_in;
   logic             layer_ff, layer_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [HW_AW-1:0] hw_addr_ff, hw_addr_in;
   logic [OW_AW-1:0] ow_addr_ff, ow_addr_in;
   logic             p1_v_ff, p2_v_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [29:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [15:0]             u_ff, u_in;
   logic [16:0]             qe_ff;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [N_W-1:0]          best_ff, best_in;
   logic [12:0]             best_act_ff, best_act_in;
   rsp_item_type            rsp_data_ff, rsp_data_in;

   logic [12:0] act_q;

   // request decode
   logic               req_accept;
   logic               hw_we, ow_we, hb_we, ob_we, px_we, start;
   logic [HW_AW-1:0]   hw_wr_addr;
   logic [OW_AW-1:0]   ow_wr_addr;
   logic [12:0]        px_val;
   logic               ha_we;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign hw_wr_addr = HW_AW'(32'(req_data.row_index) * INPUT_COUNT
                       + 32'(req_data.column_index));
   assign ow_wr_addr = OW_AW'(32'(req_data.row_index) * HIDDEN_COUNT
                       + 32'(req_data.column_index));

   // pixel saturation to [0, 4096]
   always_comb begin
      if (req_data.value < 0)               px_val = 13'd0;
      else if (req_data.value > PIXEL_MAX)  px_val = 13'(PIXEL_MAX);
      else                                  px_val = req_data.value[12:0];
   end

   always_comb begin
      hw_we = 1'b0;
      ow_we = 1'b0;
      hb_we = 1'b0;
      ob_we = 1'b0;
      px_we = 1'b0;
      start = 1'b0;
      if (req_accept) begin
         unique case (req_data.req_type)
            REQ_WEIGHT: begin
               if (!req_data.layer_select)
                  hw_we = (32'(req_data.row_index) < HIDDEN_COUNT)
                          && (32'(req_data.column_index) < INPUT_COUNT);
               else
                  ow_we = (32'(req_data.row_index) < OUTPUT_COUNT)
                          && (32'(req_data.column_index) < HIDDEN_COUNT);
            end
            REQ_BIAS: begin
               if (!req_data.layer_select)
                  hb_we = 32'(req_data.row_index) < HIDDEN_COUNT;
               else
                  ob_we = 32'(req_data.row_index) < OUTPUT_COUNT;
            end
            REQ_PIXEL: begin
               px_we = 32'(req_data.column_index) < INPUT_COUNT;
               start = req_data.last;
            end
            default: begin
            end
         endcase
      end
   end

   // memories: one write port, registered read
   always_ff @(posedge clock) begin
      if (hw_we) hw_mem[hw_wr_addr] <= req_data.value;
      hw_rd_ff <= hw_mem[hw_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (ow_we) ow_mem[ow_wr_addr] <= req_data.value;
      ow_rd_ff <= ow_mem[ow_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (hb_we) hb_mem[req_data.row_index[HB_AW-1:0]] <= req_data.value;
      hb_rd_ff <= hb_mem[n_ff[HB_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ob_we) ob_mem[req_data.row_index[OB_AW-1:0]] <= req_data.value;
      ob_rd_ff <= ob_mem[n_ff[OB_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (px_we) px_mem[req_data.column_index[PX_AW-1:0]] <= px_val;
      px_rd_ff <= px_mem[i_ff[PX_AW-1:0]];
   end

   assign ha_we = (state_ff == S_STORE) && !layer_ff;

   always_ff @(posedge clock) begin
      if (ha_we) ha_mem[n_ff[HB_AW-1:0]] <= act_q;
      ha_rd_ff <= ha_mem[i_ff[HB_AW-1:0]];
   end

   // sigmoid table
   mlpsc_sigmoid_rom #(
      .DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sigmoid_rom (
      .clock    (clock),
      .rd_index (idx_ff),
      .rd_data  (act_q)
   );

   // multiply stage
   logic signed [15:0] w_sel;
   logic [12:0]        x_sel;

   assign w_sel = layer_ff ? ow_rd_ff : hw_rd_ff;
   assign x_sel = layer_ff ? ha_rd_ff : px_rd_ff;

   always_ff @(posedge clock) begin
      prod_ff <= w_sel * $signed({1'b0, x_sel});
   end

   // neuron sum, shift, bias and saturation
   logic signed [ZW-1:0] z_sum;
   logic signed [15:0]   bias_sel;
   logic signed [15:0]   z_sat;

   assign bias_sel = layer_ff ? ob_rd_ff : hb_rd_ff;
   assign z_sum    = ZW'(acc_ff >>> 12) + ZW'(bias_sel);

   always_comb begin
      if (z_sum < Z_MIN)      z_sat = 16'sh8000;
      else if (z_sum > Z_MAX) z_sat = 16'sh7fff;
      else                    z_sat = z_sum[15:0];
   end

   // table index: reciprocal estimate, then one correction
   logic [48:0] q_prod;
   logic [33:0] q_back;
   logic [33:0] q_rem;
   logic [16:0] q_fix;

   assign q_prod = 49'(u_ff) * 49'(RECIP);
   assign q_back = 34'(qe_ff) * 34'(STEP);
   assign q_rem  = 34'(u_ff) - q_back;
   assign q_fix  = (q_rem >= 34'(STEP)) ? qe_ff + 17'd1 : qe_ff;
   assign idx_in = (32'(q_fix) >= SIGMOID_TABLE_DEPTH) ? IDX_W'(SIGMOID_TABLE_DEPTH - 1)
                                                       : IDX_W'(q_fix);

   // sequencer
   logic [CNT_W-1:0] last_col;
   logic [N_W-1:0]   last_row;
   logic             out_free;

   assign last_col = layer_ff ? CNT_W'(HIDDEN_COUNT - 1) : CNT_W'(INPUT_COUNT - 1);
   assign last_row = layer_ff ? N_W'(OUTPUT_COUNT - 1) : N_W'(HIDDEN_COUNT - 1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign u_in     = {~z_sat[15], z_sat[14:0]};

   always_comb begin
      state_in     = state_ff;
      layer_in     = layer_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      hw_addr_in   = hw_addr_ff;
      ow_addr_in   = ow_addr_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      best_act_in  = best_act_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (p2_v_ff) acc_in = acc_ff + ACC_W'(prod_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = S_MAC;
               layer_in   = 1'b0;
               n_in       = '0;
               i_in       = '0;
               hw_addr_in = '0;
               ow_addr_in = '0;
               acc_in     = '0;
            end
         end
         S_MAC: begin
            if (layer_ff) ow_addr_in = ow_addr_ff + OW_AW'(1);
            else          hw_addr_in = hw_addr_ff + HW_AW'(1);
            i_in = i_ff + CNT_W'(1);
            if (i_ff == last_col) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff) state_in = S_DIV;
         end
         S_DIV:  state_in = S_ACT;
         S_ACT:  state_in = S_ROM;
         S_ROM:  state_in = S_STORE;
         S_STORE: begin
            // argmax, lowest index wins ties
            if (layer_ff && (n_ff == '0 || act_q > best_act_ff)) begin
               best_in     = n_ff;
               best_act_in = act_q;
            end
            i_in   = '0;
            acc_in = '0;
            if (n_ff == last_row) begin
               n_in = '0;
               if (layer_ff) begin
                  state_in = S_DONE;
               end else begin
                  layer_in = 1'b1;
                  state_in = S_MAC;
               end
            end else begin
               n_in     = n_ff + N_W'(1);
               state_in = S_MAC;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.predicted_class = 4'(best_ff);
               rsp_data_in.top_activation  = best_act_ff;
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         layer_ff     <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         hw_addr_ff   <= '0;
         ow_addr_ff   <= '0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         hw_addr_ff   <= hw_addr_in;
         ow_addr_ff   <= ow_addr_in;
         p1_v_ff      <= (state_ff == S_MAC);
         p2_v_ff      <= p1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath state
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      best_act_ff <= best_act_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_DRAIN) u_ff <= u_in;
      if (state_ff == S_DIV)   qe_ff <= q_prod[48:32];
      if (state_ff == S_ACT)   idx_ff <= idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/mlpsc_checker.sv
// ---------------------------------------------------------------------------
// mlpsc_checker
// port-level assertions for the classifier, bound to the top level
// ---------------------------------------------------------------------------
`include "mlp_two_layer_sigmoid_classifier_macros.svh"

module mlpsc_checker #(
   parameter int OUTPUT_COUNT = 10
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input mlpsc_pkg::req_item_type req_data,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input mlpsc_pkg::rsp_item_type rsp_data
);
   import mlpsc_pkg::*;

   // a stalled result holds its data
   `MLPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // results stay in range
   `MLPSC_ASSERT_NOW(a_rsp_range, clock, reset, rsp_valid, (32'(rsp_data.predicted_class) < OUTPUT_COUNT) && (rsp_data.top_activation <= 13'd4096), "rsp out of range")

   // a last pixel starts inference and blocks further requests
   `MLPSC_ASSERT_NEXT(a_start_stall, clock, reset, req_valid && !req_stall && (req_data.req_type == REQ_PIXEL) && req_data.last, req_stall, "no stall after last pixel")

   // a new result only appears at the end of an inference
   `MLPSC_ASSERT_NOW(a_rsp_after_run, clock, reset, $rose(rsp_valid), $past(req_stall), "result without inference")

endmodule

bind mlp_two_layer_sigmoid_classifier mlpsc_checker #(
   .OUTPUT_COUNT (OUTPUT_COUNT)
) u_mlpsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
